FILE: rtl/signed_int_to_decimal_ascii_macros.svh
// Assertion helpers used by the serializer module.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define S2A_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define S2A_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/s2a_pkg.sv
package s2a_pkg;

  localparam int CHAR_W = 6;
  localparam int BCD_W = 4;
  // Double-dabble shift steps folded into one pipeline stage.
  localparam int STEPS_PER_STAGE = 4;

  localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 6'd45;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [BCD_W-1:0] bcd_digit_t;

endpackage

FILE: rtl/s2a_ifs.sv
interface s2a_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface s2a_out_if;
  logic           valid;
  logic           ready;
  s2a_pkg::char_t character;
  logic           last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

FILE: rtl/s2a_bcd_pipe.sv
module s2a_bcd_pipe #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG = 10,
  parameter int IDXW = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [VALUE_BITS-1:0]         in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_neg,
  output logic [NDIG*s2a_pkg::BCD_W-1:0] out_bcd,
  output logic [IDXW-1:0]               out_msd
);

  localparam int SPS = s2a_pkg::STEPS_PER_STAGE;
  localparam int NDAB = (VALUE_BITS + SPS - 1) / SPS;
  localparam int NST = NDAB + 2;
  localparam int BCDW = NDIG * s2a_pkg::BCD_W;
  localparam int W = BCDW + VALUE_BITS;

  // Stage 0 forms the magnitude, stages 1..NDAB run double dabble,
  // and the final stage locates the most significant nonzero digit.
  logic           vld_r [NST];
  logic           rdy   [NST];
  logic           neg_r [NST];
  logic [W-1:0]   vec_r [NST];
  logic [IDXW-1:0] msd_r;

  function automatic logic [W-1:0] dabble(input logic [W-1:0] v, input int nsteps);
    logic [W-1:0] t;
    t = v;
    for (int k = 0; k < SPS; k++) begin
      if (k < nsteps) begin
        for (int d = 0; d < NDIG; d++) begin
          if (t[VALUE_BITS+d*s2a_pkg::BCD_W +: s2a_pkg::BCD_W] >= 4'd5) begin
            t[VALUE_BITS+d*s2a_pkg::BCD_W +: s2a_pkg::BCD_W] =
              t[VALUE_BITS+d*s2a_pkg::BCD_W +: s2a_pkg::BCD_W] + 4'd3;
          end
        end
        t = t << 1;
      end
    end
    return t;
  endfunction

  function automatic logic [IDXW-1:0] lead_digit(input logic [BCDW-1:0] b);
    logic [IDXW-1:0] m;
    m = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (b[d*s2a_pkg::BCD_W +: s2a_pkg::BCD_W] != '0) begin
        m = IDXW'(d);
      end
    end
    return m;
  endfunction

  assign in_ready = rdy[0];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    if (s == NST - 1) begin : g_rdy_last
      assign rdy[s] = !vld_r[s] || out_ready;
    end else begin : g_rdy_mid
      assign rdy[s] = !vld_r[s] || rdy[s+1];
    end

    if (s == 0) begin : g_abs
      logic [VALUE_BITS-1:0] mag;
      assign mag = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          vld_r[s] <= in_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s] && in_valid) begin
          neg_r[s] <= in_value[VALUE_BITS-1];
          vec_r[s] <= {{BCDW{1'b0}}, mag};
        end
      end
    end else if (s <= NDAB) begin : g_dab
      localparam int REM = VALUE_BITS - (s - 1) * SPS;
      localparam int NSTEP = (REM < SPS) ? REM : SPS;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s] && vld_r[s-1]) begin
          neg_r[s] <= neg_r[s-1];
          vec_r[s] <= dabble(vec_r[s-1], NSTEP);
        end
      end
    end else begin : g_lead
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s] && vld_r[s-1]) begin
          neg_r[s] <= neg_r[s-1];
          vec_r[s] <= vec_r[s-1];
          msd_r    <= lead_digit(vec_r[s-1][W-1:VALUE_BITS]);
        end
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_neg   = neg_r[NST-1];
  assign out_bcd   = vec_r[NST-1][W-1:VALUE_BITS];
  assign out_msd   = msd_r;

endmodule

FILE: rtl/s2a_ser.sv
`include "signed_int_to_decimal_ascii_macros.svh"

module s2a_ser #(
  parameter int NDIG = 10,
  parameter int IDXW = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_neg,
  input  logic [NDIG*s2a_pkg::BCD_W-1:0] in_bcd,
  input  logic [IDXW-1:0]                in_msd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output s2a_pkg::char_t                 out_character,
  output logic                           out_last
);

  // Holding register for the number being spelled out.
  logic                           hld_vld_r, hld_vld_nxt;
  logic                           neg_pend_r, neg_pend_nxt;
  logic [IDXW-1:0]                idx_r, idx_nxt;
  logic [NDIG*s2a_pkg::BCD_W-1:0] dig_r;

  // Output register.
  logic           ov_r, ov_nxt;
  s2a_pkg::char_t ochar_r, ochar_nxt;
  logic           olast_r, olast_nxt;

  logic                   out_move;
  logic                   take;
  logic                   cur_last;
  logic                   load;
  s2a_pkg::bcd_digit_t    cur_digit;

  assign out_move  = !ov_r || out_ready;
  assign take      = hld_vld_r && out_move;
  assign cur_last  = !neg_pend_r && (idx_r == '0);
  assign cur_digit = dig_r[idx_r*s2a_pkg::BCD_W +: s2a_pkg::BCD_W];
  assign in_ready  = !hld_vld_r || (take && cur_last);
  assign load      = in_valid && in_ready;

  always_comb begin
    hld_vld_nxt  = hld_vld_r;
    neg_pend_nxt = neg_pend_r;
    idx_nxt      = idx_r;
    if (take) begin
      if (neg_pend_r) begin
        neg_pend_nxt = 1'b0;
      end else if (cur_last) begin
        hld_vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end
    if (load) begin
      hld_vld_nxt  = 1'b1;
      neg_pend_nxt = in_neg;
      idx_nxt      = in_msd;
    end
  end

  always_comb begin
    ov_nxt    = ov_r;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    if (out_move) begin
      ov_nxt    = hld_vld_r;
      ochar_nxt = neg_pend_r ? s2a_pkg::MINUS_CHAR
                             : s2a_pkg::DIGIT_BASE + {2'b00, cur_digit};
      olast_nxt = cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hld_vld_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      hld_vld_r <= hld_vld_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_pend_r <= neg_pend_nxt;
    idx_r      <= idx_nxt;
    ochar_r    <= ochar_nxt;
    olast_r    <= olast_nxt;
    if (load) begin
      dig_r <= in_bcd;
    end
  end

  assign out_valid     = ov_r;
  assign out_character = ochar_r;
  assign out_last      = olast_r;

  `S2A_ASSERT_SAME(a_idx_range, clk, rst_n, hld_vld_r, int'(idx_r) < NDIG, "digit index out of range")
  `S2A_ASSERT_NEXT(a_mid_busy, clk, rst_n, take && !cur_last, hld_vld_r, "number dropped before its last character")
  `S2A_ASSERT_SAME(a_last_digit, clk, rst_n, ov_r && olast_r, ochar_r != s2a_pkg::MINUS_CHAR, "text ends on a minus sign")
  `S2A_ASSERT_SAME(a_char_set, clk, rst_n, ov_r, (ochar_r == s2a_pkg::MINUS_CHAR) || ((ochar_r >= s2a_pkg::DIGIT_BASE) && (ochar_r <= s2a_pkg::DIGIT_BASE + 6'd9)), "character outside the decimal set")

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// The first character passes the magnitude, double-dabble and digit-search stages, then the
// serializer's holding and output registers after the input transfer.
// Throughput: one character per cycle while the receiver is ready; a number is 1 to 11
// characters at 32 bits. Inputs are taken one per cycle until the pipeline stages fill;
// after that an input is taken only when the serializer takes the last character it holds.
// Reset (synchronous, active low) clears only the valid bits; data registers are not reset.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  s2a_in_if.sink           in_ch,
  s2a_out_if.source        out_ch
);

  localparam int NDIG = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int IDXW = $clog2(NDIG);

  logic                           pv;
  logic                           pr;
  logic                           pneg;
  logic [NDIG*s2a_pkg::BCD_W-1:0] pbcd;
  logic [IDXW-1:0]                pmsd;

  s2a_bcd_pipe #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG),
    .IDXW       (IDXW)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_value  (in_ch.value),
    .out_valid (pv),
    .out_ready (pr),
    .out_neg   (pneg),
    .out_bcd   (pbcd),
    .out_msd   (pmsd)
  );

  s2a_ser #(
    .NDIG (NDIG),
    .IDXW (IDXW)
  ) u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pv),
    .in_ready      (pr),
    .in_neg        (pneg),
    .in_bcd        (pbcd),
    .in_msd        (pmsd),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_character (out_ch.character),
    .out_last      (out_ch.last)
  );

endmodule

FILE: bench/signed_int_to_decimal_ascii_tb.sv
module signed_int_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS = 32;
  localparam int RADIX = 10;
  localparam int QUIET_LIMIT = 2000;
  localparam int LATENCY_TAIL = 40;

  typedef struct packed {
    s2a_pkg::char_t character;
    logic           last;
  } ascii_char_t;

  logic clk = 1'b0;
  logic rst_n;

  s2a_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  s2a_out_if out_ch ();

  signed_int_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [VALUE_BITS-1:0] pending_values [$];
  ascii_char_t           expected_text [$];
  ascii_char_t           oldest_char;
  int unsigned           sender_idle_pct;
  int unsigned           recv_stall_pct;
  int unsigned           quiet_cycles;
  int                    mismatch_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Appends the decimal text of one number, most significant character first.
  function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] mag;
    s2a_pkg::bcd_digit_t   digits [$];
    ascii_char_t           one_char;
    mag = value[VALUE_BITS-1] ? -value : value;
    do begin
      digits.push_front(s2a_pkg::bcd_digit_t'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    if (value[VALUE_BITS-1]) begin
      one_char.character = s2a_pkg::MINUS_CHAR;
      one_char.last = 1'b0;
      expected_text.push_back(one_char);
    end
    foreach (digits[i]) begin
      one_char.character = s2a_pkg::char_t'(s2a_pkg::DIGIT_BASE + digits[i]);
      one_char.last = (i == digits.size() - 1);
      expected_text.push_back(one_char);
    end
  endfunction

  // Three calls in four pick a digit count so short and long numbers are equally common.
  function automatic logic [VALUE_BITS-1:0] random_value();
    int unsigned           ndigits;
    int unsigned           lo;
    int unsigned           hi;
    logic [VALUE_BITS-1:0] mag;
    if ($urandom_range(3) == 0) begin
      return $urandom();
    end
    ndigits = $urandom_range(10, 1);
    lo = 1;
    repeat (ndigits - 1) lo = lo * RADIX;
    hi = (ndigits == 10) ? 32'd2147483647 : lo * RADIX - 1;
    if (ndigits == 1) begin
      lo = 0;
    end
    mag = $urandom_range(hi, lo);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // Driver: a new value is offered once the previous one has been transferred.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_text(in_ch.value);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_values.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.value <= pending_values.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every transferred character is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          $error("character %0d arrived with no character expected", out_ch.character);
          mismatch_count++;
        end else begin
          oldest_char = expected_text.pop_front();
          if (out_ch.character !== oldest_char.character) begin
            $error("character: expected %0d, actual %0d",
                   oldest_char.character, out_ch.character);
            mismatch_count++;
          end
          if (out_ch.last !== oldest_char.last) begin
            $error("last: expected %0b, actual %0b", oldest_char.last, out_ch.last);
            mismatch_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Polled on the falling edge so that all updates of the rising edge are settled.
  task automatic drain();
    @(negedge clk);
    while (pending_values.size() > 0 || in_ch.valid || expected_text.size() > 0) begin
      @(negedge clk);
    end
  endtask

  task automatic queue_random(input int count);
    repeat (count) pending_values.push_back(random_value());
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single digits, carries into a new digit, both extremes and alternating bit patterns.
    pending_values = '{32'd0, 32'd1, 32'd7, 32'd9, 32'd10, 32'd99, 32'd100,
                       -32'sd1, -32'sd9, -32'sd10, -32'sd11,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                       32'd999999999, 32'd1000000000, -32'sd999999999, -32'sd1000000000,
                       32'd123456789, -32'sd987654321, 32'h5555_5555, 32'hAAAA_AAAA,
                       32'h4000_0000};
    queue_random(27);
    drain();

    sender_idle_pct = 79;
    queue_random(30);
    // The sender holds off here until the block has delivered every character.
    drain();
    queue_random(30);
    drain();

    sender_idle_pct = 0;
    recv_stall_pct = 79;
    queue_random(60);
    drain();

    sender_idle_pct = 21;
    recv_stall_pct = 21;
    queue_random(60);
    drain();

    repeat (LATENCY_TAIL) @(posedge clk);
    @(negedge clk);
    if (expected_text.size() != 0) begin
      $error("%0d expected characters never arrived", expected_text.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
